### sv/vvps_pkg.sv
// ----------------------------------------------------------------------------
// Velocity Verlet particle step: shared definitions
// Fixed-point widths, register indexes, phase codes and the payload
// structures of the particle and result channels.
// ----------------------------------------------------------------------------
package vvps_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DT_BITS       = 16;
	localparam int POS_W         = 31;
	localparam int VEL_W         = 32;
	localparam int CFG_W         = 32;

	typedef logic [1:0] cfg_idx_t;

	localparam cfg_idx_t REG_TIME_STEP    = 2'd0;
	localparam cfg_idx_t REG_INVERSE_MASS = 2'd1;
	localparam cfg_idx_t REG_BOX_LENGTH   = 2'd2;

	localparam logic FUNC_DRIFT = 1'b0;
	localparam logic FUNC_KICK  = 1'b1;

	typedef logic [POS_W-1:0]        pos_t;
	typedef logic signed [VEL_W-1:0] vel_t;

	typedef struct packed {
		logic func;
		pos_t pos_x;
		pos_t pos_y;
		pos_t pos_z;
		vel_t vel_x;
		vel_t vel_y;
		vel_t vel_z;
		vel_t force_x;
		vel_t force_y;
		vel_t force_z;
		logic last_in;
	} particle_t;

	typedef struct packed {
		pos_t new_pos_x;
		pos_t new_pos_y;
		pos_t new_pos_z;
		vel_t new_vel_x;
		vel_t new_vel_y;
		vel_t new_vel_z;
		logic last_out;
		logic out_of_range;
	} result_t;

endpackage

### sv/vvps_particle_if.sv
// ----------------------------------------------------------------------------
// Particle channel
// Valid/ready channel carrying one particle per transaction.
// ----------------------------------------------------------------------------
interface vvps_particle_if;
	import vvps_pkg::*;

	logic      valid;
	logic      ready;
	particle_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### sv/vvps_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one updated particle per transaction.
// ----------------------------------------------------------------------------
interface vvps_result_if;
	import vvps_pkg::*;

	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### sv/velocity_verlet_particle_step_core.sv
// Velocity Verlet step core: takes one particle and returns one result per
// clock while result.ready holds. Each axis has its own lane of three
// multipliers (force by half step, by inverse mass, and velocity by step),
// each followed by a register, in a six-stage pipeline whose throughput is
// one transaction per cycle unless stalled. A stalled result only holds the
// stages that are full; bubbles upstream still close up. Configuration
// writes take effect at once and should be made while idle.
// ----------------------------------------------------------------------------
// Velocity Verlet particle step core
// Half-kick, drift and periodic wrap of one particle per transaction in signed
// fixed point, with velocity saturation and an out-of-range flag.
// ----------------------------------------------------------------------------
module velocity_verlet_particle_step_core #(
	parameter int FRAC_BITS = vvps_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  vvps_pkg::cfg_idx_t          cfg_idx,
	input  logic [vvps_pkg::CFG_W-1:0]  cfg_wdata,
	vvps_particle_if.sink               particle,
	vvps_result_if.source               result
);
	import vvps_pkg::*;

	localparam int P1_W  = 48;
	localparam int T_W   = 31;
	localparam int P2_W  = 63;
	localparam int DV_W  = P2_W - FRAC_BITS;
	localparam int SUM_W = DV_W + 1;
	localparam int P3_W  = 48;
	localparam int PX_W  = 34;

	// configuration
	logic [15:0]      ts_q;
	logic [31:0]      inv_q;
	logic [POS_W-1:0] box_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q  <= 16'd328;
			inv_q <= 32'd65536;
			box_q <= 31'd655360;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_TIME_STEP:    ts_q  <= cfg_wdata[15:0];
				REG_INVERSE_MASS: inv_q <= cfg_wdata[31:0];
				REG_BOX_LENGTH:   box_q <= cfg_wdata[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// stage handshake
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	assign rdy6 = !valid_s6 || result.ready;
	assign rdy5 = !valid_s5 || rdy6;
	assign rdy4 = !valid_s4 || rdy5;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;

	assign particle.ready = rdy1;
	assign result.valid   = valid_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= particle.valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
			if (rdy6) valid_s6 <= valid_s5;
		end
	end

	// per-lane inputs
	pos_t pos_in [3];
	vel_t vel_in [3];
	vel_t frc_in [3];

	always_comb begin
		pos_in[0] = particle.data.pos_x;
		pos_in[1] = particle.data.pos_y;
		pos_in[2] = particle.data.pos_z;
		vel_in[0] = particle.data.vel_x;
		vel_in[1] = particle.data.vel_y;
		vel_in[2] = particle.data.vel_z;
		frc_in[0] = particle.data.force_x;
		frc_in[1] = particle.data.force_y;
		frc_in[2] = particle.data.force_z;
	end

	// pipeline registers
	logic                    func_s1, func_s2, func_s3, func_s4, func_s5;
	logic                    last_s1, last_s2, last_s3, last_s4, last_s5;
	pos_t                    pos_s1 [3];
	pos_t                    pos_s2 [3];
	pos_t                    pos_s3 [3];
	pos_t                    pos_s4 [3];
	vel_t                    vel_s1 [3];
	vel_t                    vel_s2 [3];
	logic signed [P1_W-1:0]  kp_s1 [3];
	logic signed [P2_W-1:0]  mp_s2 [3];
	vel_t                    v_s3 [3];
	vel_t                    v_s4 [3];
	vel_t                    v_s5 [3];
	logic signed [P3_W-1:0]  dp_s4 [3];
	logic signed [PX_W-1:0]  p_s5 [3];
	result_t                 out_s6;

	// lane arithmetic
	logic signed [16:0]      half_dt;
	logic signed [16:0]      dt_ext;
	logic signed [32:0]      inv_ext;
	logic signed [P1_W-1:0]  kp_d [3];
	logic signed [T_W-1:0]   t_d [3];
	logic signed [63:0]      mp_full [3];
	logic signed [DV_W-1:0]  dv_d [3];
	logic signed [SUM_W-1:0] sum_d [3];
	logic [SUM_W-32:0]       sum_hi [3];
	vel_t                    v_d [3];
	logic signed [P3_W:0]    dp_full [3];
	logic signed [VEL_W-1:0] dx_d [3];
	logic signed [PX_W-1:0]  p_d [3];

	// wrap and clamp
	logic signed [PX_W-1:0] box_ext;
	logic [POS_W-1:0]       box_m1;
	logic signed [PX_W-1:0] w_d [3];
	pos_t                   np_d [3];
	logic [2:0]             oor_d;
	result_t                out_d;

	always_comb begin
		half_dt = {2'b00, ts_q[15:1]};
		dt_ext  = {1'b0, ts_q};
		inv_ext = {1'b0, inv_q};
		for (int a = 0; a < 3; a++) begin
			kp_d[a]    = P1_W'(frc_in[a] * half_dt);
			t_d[a]     = kp_s1[a][DT_BITS +: T_W];
			mp_full[a] = t_d[a] * inv_ext;
			dv_d[a]    = mp_s2[a][P2_W-1:FRAC_BITS];
			sum_d[a]   = SUM_W'(dv_d[a]) + SUM_W'(vel_s2[a]);
			sum_hi[a]  = sum_d[a][SUM_W-1:31];
			if ((&sum_hi[a]) || !(|sum_hi[a])) begin
				v_d[a] = sum_d[a][31:0];
			end else if (sum_d[a][SUM_W-1]) begin
				v_d[a] = {1'b1, 31'd0};
			end else begin
				v_d[a] = {1'b0, {31{1'b1}}};
			end
			dp_full[a] = v_s3[a] * dt_ext;
			dx_d[a]    = dp_s4[a][DT_BITS +: VEL_W];
			p_d[a]     = PX_W'({1'b0, pos_s4[a]}) + PX_W'(dx_d[a]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && particle.valid) begin
			func_s1 <= particle.data.func;
			last_s1 <= particle.data.last_in;
			for (int a = 0; a < 3; a++) begin
				pos_s1[a] <= pos_in[a];
				vel_s1[a] <= vel_in[a];
				kp_s1[a]  <= kp_d[a];
			end
		end
		if (rdy2 && valid_s1) begin
			func_s2 <= func_s1;
			last_s2 <= last_s1;
			for (int a = 0; a < 3; a++) begin
				pos_s2[a] <= pos_s1[a];
				vel_s2[a] <= vel_s1[a];
				mp_s2[a]  <= mp_full[a][P2_W-1:0];
			end
		end
		if (rdy3 && valid_s2) begin
			func_s3 <= func_s2;
			last_s3 <= last_s2;
			for (int a = 0; a < 3; a++) begin
				pos_s3[a] <= pos_s2[a];
				v_s3[a]   <= v_d[a];
			end
		end
		if (rdy4 && valid_s3) begin
			func_s4 <= func_s3;
			last_s4 <= last_s3;
			for (int a = 0; a < 3; a++) begin
				pos_s4[a] <= pos_s3[a];
				v_s4[a]   <= v_s3[a];
				dp_s4[a]  <= dp_full[a][P3_W-1:0];
			end
		end
		if (rdy5 && valid_s4) begin
			func_s5 <= func_s4;
			last_s5 <= last_s4;
			for (int a = 0; a < 3; a++) begin
				v_s5[a] <= v_s4[a];
				p_s5[a] <= (func_s4 == FUNC_KICK) ? PX_W'({1'b0, pos_s4[a]}) : p_d[a];
			end
		end
		if (rdy6 && valid_s5) begin
			out_s6 <= out_d;
		end
	end

	always_comb begin
		box_ext = PX_W'({1'b0, box_q});
		box_m1  = (box_q != '0) ? box_q - POS_W'(1) : '0;
		for (int a = 0; a < 3; a++) begin
			if (p_s5[a] < 0) begin
				w_d[a] = p_s5[a] + box_ext;
			end else if (p_s5[a] >= box_ext) begin
				w_d[a] = p_s5[a] - box_ext;
			end else begin
				w_d[a] = p_s5[a];
			end
			if (func_s5 == FUNC_KICK) begin
				np_d[a]  = p_s5[a][POS_W-1:0];
				oor_d[a] = 1'b0;
			end else if (w_d[a] < 0) begin
				np_d[a]  = '0;
				oor_d[a] = 1'b1;
			end else if (w_d[a] >= box_ext) begin
				np_d[a]  = box_m1;
				oor_d[a] = 1'b1;
			end else begin
				np_d[a]  = w_d[a][POS_W-1:0];
				oor_d[a] = 1'b0;
			end
		end
		out_d.new_pos_x    = np_d[0];
		out_d.new_pos_y    = np_d[1];
		out_d.new_pos_z    = np_d[2];
		out_d.new_vel_x    = v_s5[0];
		out_d.new_vel_y    = v_s5[1];
		out_d.new_vel_z    = v_s5[2];
		out_d.last_out     = last_s5;
		out_d.out_of_range = |oor_d;
	end

	assign result.data = out_s6;

endmodule
